[design/qkc_pkg.sv]
// Shared types and constants of the quaternion keyframe conditioner.
package qkc_pkg;

    localparam int QUAT_W      = 16;
    localparam int TIME_W      = 32;
    localparam int LEN_W       = 31;
    localparam int DOT_W       = 2 * QUAT_W + 2;
    localparam int IN_DATA_W   = 96;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 128;
    localparam int OUT_USER_W  = 2;

    typedef enum logic {
        OP_KEYFRAME = 1'b0,
        OP_END_ANIM = 1'b1
    } t_op;

    typedef logic signed [QUAT_W-1:0] t_quat;
    typedef logic signed [TIME_W-1:0] t_time;

    typedef struct packed {
        t_op                operation;
        t_quat              rot_x;
        t_quat              rot_y;
        t_quat              rot_z;
        t_quat              rot_w;
        t_time              abs_time;
        logic               first_of_sequence;
        logic               last_of_sequence;
    } t_in_item;

    typedef struct packed {
        logic               is_total;
        t_quat              out_x;
        t_quat              out_y;
        t_quat              out_z;
        t_quat              out_w;
        t_time              delta_time;
        logic               flipped;
        logic [LEN_W-1:0]   total_length;
    } t_out_item;

    typedef struct packed {
        logic               valid;
        logic               advance;
    } t_stage_ctl;

endpackage

[design/qkc_in_stage.sv]
// Input register stage that holds one accepted item for the core.
module qkc_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  qkc_pkg::t_in_item i_item,
    input  logic            i_advance,
    output qkc_pkg::t_stage_ctl o_ctl,
    output qkc_pkg::t_in_item o_item
);
    import qkc_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_advance;

    always_comb begin
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_ctl.valid   = r_valid;
    assign o_ctl.advance = i_advance;
    assign o_item        = r_item;

endmodule

[design/qkc_core.sv]
// Hemisphere test, delta time and running length with the per-sequence state.
module qkc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qkc_pkg::t_stage_ctl i_ctl,
    input  qkc_pkg::t_in_item i_item,
    output qkc_pkg::t_out_item o_result
);
    import qkc_pkg::*;

    t_quat              r_prev_x, r_prev_y, r_prev_z, r_prev_w;
    t_time              r_prev_time;
    logic               r_have_prev;
    logic [LEN_W-1:0]   r_max_len;

    logic signed [2*QUAT_W-1:0] w_prod_x, w_prod_y, w_prod_z, w_prod_w;
    logic signed [DOT_W-1:0]    w_dot;
    logic signed [TIME_W:0]     w_diff;
    t_time                      w_delta;
    logic                       w_first;
    logic                       w_flip;
    logic                       w_raise;
    t_quat                      w_qx, w_qy, w_qz, w_qw;
    logic                       w_end;

    assign w_end   = (i_item.operation == OP_END_ANIM);
    assign w_first = i_item.first_of_sequence || !r_have_prev;

    assign w_prod_x = r_prev_x * i_item.rot_x;
    assign w_prod_y = r_prev_y * i_item.rot_y;
    assign w_prod_z = r_prev_z * i_item.rot_z;
    assign w_prod_w = r_prev_w * i_item.rot_w;
    assign w_dot = DOT_W'(w_prod_x) + DOT_W'(w_prod_y)
                 + DOT_W'(w_prod_z) + DOT_W'(w_prod_w);

    assign w_flip = !w_first && w_dot[DOT_W-1];

    assign w_qx = w_flip ? -i_item.rot_x : i_item.rot_x;
    assign w_qy = w_flip ? -i_item.rot_y : i_item.rot_y;
    assign w_qz = w_flip ? -i_item.rot_z : i_item.rot_z;
    assign w_qw = w_flip ? -i_item.rot_w : i_item.rot_w;

    assign w_diff = (TIME_W+1)'(i_item.abs_time) - (TIME_W+1)'(r_prev_time);

    always_comb begin
        if (w_first) begin
            w_delta = i_item.abs_time;
        end else if (w_diff[TIME_W] != w_diff[TIME_W-1]) begin
            w_delta = w_diff[TIME_W] ? {1'b1, {(TIME_W-1){1'b0}}}
                                     : {1'b0, {(TIME_W-1){1'b1}}};
        end else begin
            w_delta = w_diff[TIME_W-1:0];
        end
    end

    assign w_raise = i_item.last_of_sequence && !i_item.abs_time[TIME_W-1]
                  && (i_item.abs_time[LEN_W-1:0] > r_max_len);

    always_comb begin
        if (w_end) begin
            o_result.is_total     = 1'b1;
            o_result.out_x        = '0;
            o_result.out_y        = '0;
            o_result.out_z        = '0;
            o_result.out_w        = '0;
            o_result.delta_time   = '0;
            o_result.flipped      = 1'b0;
            o_result.total_length = r_max_len;
        end else begin
            o_result.is_total     = 1'b0;
            o_result.out_x        = w_qx;
            o_result.out_y        = w_qy;
            o_result.out_z        = w_qz;
            o_result.out_w        = w_qw;
            o_result.delta_time   = w_delta;
            o_result.flipped      = w_flip;
            o_result.total_length = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
            r_prev_w    <= '0;
            r_prev_time <= '0;
            r_have_prev <= 1'b0;
            r_max_len   <= '0;
        end else if (i_ctl.valid && i_ctl.advance) begin
            if (w_end) begin
                r_have_prev <= 1'b0;
                r_max_len   <= '0;
            end else begin
                r_prev_x    <= w_qx;
                r_prev_y    <= w_qy;
                r_prev_z    <= w_qz;
                r_prev_w    <= w_qw;
                r_prev_time <= i_item.abs_time;
                r_have_prev <= 1'b1;
                if (w_raise) begin
                    r_max_len <= i_item.abs_time[LEN_W-1:0];
                end
            end
        end
    end

endmodule

[design/qkc_out_stage.sv]
// Result register that holds one finished item until the consumer takes it.
module qkc_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  qkc_pkg::t_out_item i_result,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output qkc_pkg::t_out_item o_result
);
    import qkc_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_item r_result;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[design/quat_keyframe_conditioner.sv]
// Top level of the quaternion keyframe conditioner.
// The input register holds an accepted item and passes it on into the result register
// when the result register can take it; the consumer then takes the result from there.
// Throughput: one item per cycle while m_axis_tready stays high, set by the combinational
// dot product and the state update between the input register and the result register.
// Reset clears the previous quaternion and time, the have-previous flag,
// the running maximum length and both stage valid flags.
module quat_keyframe_conditioner (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // rot_x, rot_y, rot_z, rot_w, abs_time
    input  logic [qkc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // operation, first_of_sequence
    input  logic [qkc_pkg::IN_USER_W-1:0]      s_axis_tuser,
    // last_of_sequence
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_x, out_y, out_z, out_w, delta_time, total_length, one zero pad bit
    output logic [qkc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // is_total, flipped
    output logic [qkc_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
    import qkc_pkg::*;

    t_in_item   w_in_item;
    t_in_item   w_stage_item;
    t_stage_ctl w_ctl;
    t_out_item  w_core_result;
    t_out_item  w_out_result;
    logic       w_out_ready;
    logic       w_advance;

    assign w_in_item.operation         = t_op'(s_axis_tuser[0]);
    assign w_in_item.rot_x             = s_axis_tdata[15:0];
    assign w_in_item.rot_y             = s_axis_tdata[31:16];
    assign w_in_item.rot_z             = s_axis_tdata[47:32];
    assign w_in_item.rot_w             = s_axis_tdata[63:48];
    assign w_in_item.abs_time          = s_axis_tdata[95:64];
    assign w_in_item.first_of_sequence = s_axis_tuser[1];
    assign w_in_item.last_of_sequence  = s_axis_tlast;

    assign w_advance = w_ctl.valid && w_out_ready;

    qkc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_ctl     (w_ctl),
        .o_item    (w_stage_item)
    );

    qkc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_item   (w_stage_item),
        .o_result (w_core_result)
    );

    qkc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance),
        .i_result (w_core_result),
        .o_ready  (w_out_ready),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_out_result)
    );

    assign m_axis_tdata = {1'b0,
                           w_out_result.total_length,
                           w_out_result.delta_time,
                           w_out_result.out_w,
                           w_out_result.out_z,
                           w_out_result.out_y,
                           w_out_result.out_x};
    assign m_axis_tuser = {w_out_result.flipped, w_out_result.is_total};

endmodule
